// File: hdl/smd_pkg.sv
// smd_pkg: word types, constants and state enums for the sphere midpoint subdivider.
// No dependencies; used by smd_vertex, sphere_midpoint_subdivider_top and smd_checker.
package smd_pkg;

  localparam int INDEX_BITS = 20;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [15:0] NORM_ONE = 16'd16384;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_BASE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIANGLE_COUNT = 2'd2;

  localparam logic [2:0] SLOT_VERT_LAST = 3'd2;
  localparam logic [2:0] SLOT_TOP = 3'd3;
  localparam logic [2:0] SLOT_LEFT = 3'd4;
  localparam logic [2:0] SLOT_RIGHT = 3'd5;
  localparam logic [2:0] SLOT_CENTRE = 3'd6;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [INDEX_BITS-1:0] index_a;
    logic [INDEX_BITS-1:0] index_b;
    logic [INDEX_BITS-1:0] index_c;
  } in_word_t;

  typedef struct packed {
    logic kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [INDEX_BITS-1:0] tri_first;
    logic [INDEX_BITS-1:0] tri_second;
    logic [INDEX_BITS-1:0] tri_third;
    logic last;
    logic pass_done;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_START, ST_WAIT, ST_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    V_IDLE, V_SHIFT, V_SQ, V_ROOTGO, V_ROOT, V_DIVGO, V_DIV, V_SCALE, V_DONE
  } vert_state_t;

endpackage

// File: hdl/smd_isqrt.sv
// smd_isqrt: bit-serial floor square root of a 62-bit value, two radicand bits a cycle.
// Standalone; used by smd_vertex.
module smd_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        done,
  output logic [30:0] root
);

  logic [61:0] s;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] rem2;
  logic [33:0] trial;
  logic        ge;

  assign rem2  = {rem[31:0], s[61:60]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      s    <= {s[59:0], 2'b00};
      rem  <= ge ? rem2 - trial : rem2;
      root <= {root[29:0], ge};
    end
  end

endmodule

// File: hdl/smd_div.sv
// smd_div: restoring divider, one quotient bit a cycle, 16-bit quotient.
// Standalone; used by smd_vertex. Caller guarantees num < den * 2^16.
module smd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [44:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [15:0] quot
);

  logic [31:0] r;
  logic [15:0] nl;
  logic [30:0] d;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {r, nl[15]};
  assign ge = r2 >= {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r    <= {3'b000, num[44:16]};
      nl   <= num[15:0];
      d    <= den;
      quot <= '0;
    end else if (busy) begin
      r    <= ge ? 32'(r2 - {2'b00, d}) : r2[31:0];
      nl   <= {nl[14:0], 1'b0};
      quot <= {quot[14:0], ge};
    end
  end

endmodule

// File: hdl/smd_vertex.sv
// smd_vertex: normalises one midpoint to a Q2.14 normal and scales it by the radius.
// Depends on smd_pkg, smd_isqrt and smd_div.
module smd_vertex (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0][31:0]   mid,
  input  logic [30:0]        radius,
  output logic               done,
  output logic [2:0][31:0]   pos,
  output logic [2:0][15:0]   nrm
);

  smd_pkg::vert_state_t state, state_next;

  logic [2:0][31:0] u;
  logic [2:0]       neg;
  logic [31:0]      big;
  logic [61:0]      s;
  logic [30:0]      len;
  logic [14:0]      n;
  logic [1:0]       k;

  logic [2:0][31:0] mag;
  logic [31:0]      mag_max;
  logic             root_start, root_done, div_start, div_done;
  logic [30:0]      root;
  logic [15:0]      quot;
  logic [44:0]      num;
  logic [45:0]      prod;
  logic [31:0]      p;
  logic [59:0]      sq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = mid[i][31] ? 32'(-mid[i]) : mid[i];
    end
    mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mag_max = (mag[2] > mag_max) ? mag[2] : mag_max;
  end

  assign sq   = u[k][29:0] * u[k][29:0];
  assign num  = {1'b0, u[k][29:0], 14'd0} + {15'd0, len[30:1]};
  assign prod = n * radius;
  assign p    = 32'((prod + 46'd8192) >> 14);

  smd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(s), .done(root_done), .root(root)
  );

  smd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(len), .done(div_done),
    .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smd_pkg::V_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    root_start = 1'b0;
    div_start  = 1'b0;
    done       = 1'b0;
    unique case (state)
      smd_pkg::V_IDLE: begin
        if (start) begin
          state_next = (mag_max == '0) ? smd_pkg::V_DONE : smd_pkg::V_SHIFT;
        end
      end
      smd_pkg::V_SHIFT: begin
        if (big[31:30] == 2'b00 && big[29]) begin
          state_next = smd_pkg::V_SQ;
        end
      end
      smd_pkg::V_SQ: begin
        if (k == 2'd2) begin
          state_next = smd_pkg::V_ROOTGO;
        end
      end
      smd_pkg::V_ROOTGO: begin
        root_start = 1'b1;
        state_next = smd_pkg::V_ROOT;
      end
      smd_pkg::V_ROOT: begin
        if (root_done) begin
          state_next = smd_pkg::V_DIVGO;
        end
      end
      smd_pkg::V_DIVGO: begin
        div_start  = 1'b1;
        state_next = smd_pkg::V_DIV;
      end
      smd_pkg::V_DIV: begin
        if (div_done) begin
          state_next = smd_pkg::V_SCALE;
        end
      end
      smd_pkg::V_SCALE: begin
        state_next = (k == 2'd2) ? smd_pkg::V_DONE : smd_pkg::V_DIVGO;
      end
      smd_pkg::V_DONE: begin
        done       = 1'b1;
        state_next = smd_pkg::V_IDLE;
      end
      default: begin
        state_next = smd_pkg::V_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      smd_pkg::V_IDLE: begin
        if (start) begin
          u   <= mag;
          big <= mag_max;
          for (int i = 0; i < 3; i++) begin
            neg[i] <= mid[i][31];
          end
          pos <= '0;
          nrm <= '0;
        end
      end
      smd_pkg::V_SHIFT: begin
        if (big[31:30] != 2'b00) begin
          for (int i = 0; i < 3; i++) begin
            u[i] <= u[i] >> 1;
          end
          big <= big >> 1;
        end else if (!big[29]) begin
          for (int i = 0; i < 3; i++) begin
            u[i] <= u[i] << 1;
          end
          big <= big << 1;
        end else begin
          k <= '0;
          s <= '0;
        end
      end
      smd_pkg::V_SQ: begin
        s <= s + 62'(sq);
        k <= k + 2'd1;
      end
      smd_pkg::V_ROOT: begin
        if (root_done) begin
          len <= root;
          k   <= '0;
        end
      end
      smd_pkg::V_DIV: begin
        if (div_done) begin
          n <= (quot > smd_pkg::NORM_ONE) ? smd_pkg::NORM_ONE[14:0] : quot[14:0];
        end
      end
      smd_pkg::V_SCALE: begin
        nrm[k] <= neg[k] ? 16'(-{1'b0, n}) : {1'b0, n};
        pos[k] <= neg[k] ? 32'(-p) : p;
        k      <= k + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/sphere_midpoint_subdivider_top.sv
// sphere_midpoint_subdivider_top: one subdivision step per triangle, seven result words each.
// Depends on smd_pkg and smd_vertex.
//
//   channel  direction  handshake          word
//   in       into       in_valid/in_stall  smd_pkg::in_word_t, one triangle
//   out      out of     out_valid/out_stall smd_pkg::out_word_t, vertex or triangle
//   cfg      into       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One triangle at a time through the shared normaliser, which per vertex runs the shift
// steps, three squares, the square root and one division for each of three axes; a
// zero-length midpoint skips them.
// Reset (rst, synchronous) restores register defaults and clears the triangle counter.
// in_stall is low only while idle; an output stall holds the current word and the sequencer.
module sphere_midpoint_subdivider_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  smd_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output smd_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int IB = smd_pkg::INDEX_BITS;

  smd_pkg::top_state_t state, state_next;

  logic [30:0]        radius;
  logic [IB-1:0]      vertex_base;
  logic [IB-1:0]      triangle_count;
  logic [IB-1:0]      triangle_counter;

  logic [2:0][2:0][31:0] mid;
  logic [IB-1:0]      ia, ib, ic, v0, v1, v2;
  logic               done_r;
  logic [2:0]         j;

  logic               in_acc, load;
  logic [2:0][2:0][31:0] mid_in;
  logic [IB-1:0]      cnt_inc, limit, v0_in;
  logic               wrap;
  logic               vstart, vdone;
  logic [2:0][31:0]   vpos;
  logic [2:0][15:0]   vnrm;
  smd_pkg::out_word_t res;

  function automatic logic [31:0] midpt(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] sum;
    sum = $signed({a[31], a}) + $signed({b[31], b});
    return 32'(sum >>> 1);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != smd_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load      = (state == smd_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign vstart    = (state == smd_pkg::ST_START);

  always_comb begin
    mid_in[0][0] = midpt(in_data.ax, in_data.bx);
    mid_in[0][1] = midpt(in_data.ay, in_data.by);
    mid_in[0][2] = midpt(in_data.az, in_data.bz);
    mid_in[1][0] = midpt(in_data.bx, in_data.cx);
    mid_in[1][1] = midpt(in_data.by, in_data.cy);
    mid_in[1][2] = midpt(in_data.bz, in_data.cz);
    mid_in[2][0] = midpt(in_data.cx, in_data.ax);
    mid_in[2][1] = midpt(in_data.cy, in_data.ay);
    mid_in[2][2] = midpt(in_data.cz, in_data.az);
    cnt_inc = triangle_counter + 1'b1;
    limit   = (triangle_count == '0) ? IB'(1) : triangle_count;
    wrap    = (cnt_inc >= limit) || (cnt_inc == '0);
    v0_in   = vertex_base + triangle_counter + (triangle_counter << 1);
  end

  smd_vertex u_vertex (
    .clk(clk), .rst(rst), .start(vstart), .mid(mid[j[1:0]]), .radius(radius),
    .done(vdone), .pos(vpos), .nrm(vnrm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius           <= 31'd65536;
      vertex_base      <= IB'(4);
      triangle_count   <= IB'(4);
      triangle_counter <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          smd_pkg::CFG_RADIUS:         radius <= cfg_data[30:0];
          smd_pkg::CFG_VERTEX_BASE:    vertex_base <= cfg_data[IB-1:0];
          smd_pkg::CFG_TRIANGLE_COUNT: triangle_count <= cfg_data[IB-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        triangle_counter <= wrap ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid    <= mid_in;
      ia     <= in_data.index_a;
      ib     <= in_data.index_b;
      ic     <= in_data.index_c;
      v0     <= v0_in;
      v1     <= v0_in + IB'(1);
      v2     <= v0_in + IB'(2);
      done_r <= wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smd_pkg::ST_IDLE;
      j     <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        j <= '0;
      end else if (load) begin
        j <= j + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      smd_pkg::ST_IDLE:  if (in_acc) state_next = smd_pkg::ST_START;
      smd_pkg::ST_START: state_next = smd_pkg::ST_WAIT;
      smd_pkg::ST_WAIT:  if (vdone) state_next = smd_pkg::ST_EMIT;
      smd_pkg::ST_EMIT: begin
        if (load) begin
          if (j == smd_pkg::SLOT_CENTRE) begin
            state_next = smd_pkg::ST_IDLE;
          end else if (j < smd_pkg::SLOT_VERT_LAST) begin
            state_next = smd_pkg::ST_START;
          end
        end
      end
      default: state_next = smd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    unique case (j)
      smd_pkg::SLOT_TOP: begin
        res.kind = smd_pkg::KIND_TRIANGLE;
        res.tri_first = ia; res.tri_second = v0; res.tri_third = v2;
      end
      smd_pkg::SLOT_LEFT: begin
        res.kind = smd_pkg::KIND_TRIANGLE;
        res.tri_first = ib; res.tri_second = v1; res.tri_third = v0;
      end
      smd_pkg::SLOT_RIGHT: begin
        res.kind = smd_pkg::KIND_TRIANGLE;
        res.tri_first = ic; res.tri_second = v2; res.tri_third = v1;
      end
      smd_pkg::SLOT_CENTRE: begin
        res.kind = smd_pkg::KIND_TRIANGLE;
        res.tri_first = v0; res.tri_second = v1; res.tri_third = v2;
        res.last = 1'b1;
        res.pass_done = done_r;
      end
      default: begin
        res.kind   = smd_pkg::KIND_VERTEX;
        res.pos_x  = vpos[0];
        res.pos_y  = vpos[1];
        res.pos_z  = vpos[2];
        res.norm_x = vnrm[0];
        res.norm_y = vnrm[1];
        res.norm_z = vnrm[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

// File: hdl/smd_checker.sv
// smd_checker: port-level assertions for sphere_midpoint_subdivider_top, with its bind.
// Depends on smd_pkg.
module smd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input smd_pkg::out_word_t                 out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second triangle taken before the first finished");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pass_done |-> out_data.last && out_data.kind)
    else $error("pass_done without last triangle word");

  a_vertex_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.kind |-> out_data.tri_first == '0 && !out_data.last)
    else $error("vertex word carries triangle fields");

endmodule

bind sphere_midpoint_subdivider_top smd_checker u_smd_checker (.*);

// File: test/testbench.sv
// testbench: self-checking bench for sphere_midpoint_subdivider_top.
// Depends on smd_pkg and the RTL in hdl/; directed table, register extremes, then random triangles.
module testbench;

  localparam logic [smd_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  smd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  smd_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [smd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sphere_midpoint_subdivider_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [30:0] sph_radius;
  logic [19:0] first_new_index;
  logic [19:0] tris_per_pass;
  logic [19:0] tri_counter;

  smd_pkg::out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  typedef struct {
    smd_pkg::in_word_t tri_in;
    bit typed;
    smd_pkg::out_word_t first_word;
  } stim_row_t;
  stim_row_t stim_rows[$];

  function automatic void expect_word(smd_pkg::out_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [32:0] half_sum(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [32:0] t;
    t = 33'(p) + 33'(q);
    return t >>> 1;
  endfunction

  function automatic smd_pkg::out_word_t sphere_vertex(logic signed [32:0] mx,
                                                       logic signed [32:0] my,
                                                       logic signed [32:0] mz);
    smd_pkg::out_word_t w;
    logic signed [32:0] m[3];
    logic [63:0] u[3], big, s, len, n, p;
    int rs, ls;
    w = '0;
    w.kind = smd_pkg::KIND_VERTEX;
    m[0] = mx; m[1] = my; m[2] = mz;
    big = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = m[k] < 0 ? 64'(-m[k]) : 64'(m[k]);
      if (u[k] > big) big = u[k];
    end
    if (big == 0) return w;
    rs = 0; ls = 0;
    while ((big >> rs) >= (64'd1 << 30)) rs++;
    while ((big << ls) < (64'd1 << 29)) ls++;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = (u[k] >> rs) << ls;
      s += u[k] * u[k];
    end
    len = root_floor(s);
    for (int k = 0; k < 3; k++) begin
      n = (u[k] * 64'd16384 + (len >> 1)) / len;
      if (n > 64'd16384) n = 64'd16384;
      p = (n * 64'(sph_radius) + 64'd8192) >> 14;
      if (m[k] < 0) begin
        n = -n;
        p = -p;
      end
      case (k)
        0: begin w.pos_x = p[31:0]; w.norm_x = n[15:0]; end
        1: begin w.pos_y = p[31:0]; w.norm_y = n[15:0]; end
        default: begin w.pos_z = p[31:0]; w.norm_z = n[15:0]; end
      endcase
    end
    return w;
  endfunction

  function automatic smd_pkg::out_word_t tri_word(logic [19:0] i0, logic [19:0] i1,
                                                  logic [19:0] i2);
    smd_pkg::out_word_t w;
    w = '0;
    w.kind = smd_pkg::KIND_TRIANGLE;
    w.tri_first = i0; w.tri_second = i1; w.tri_third = i2;
    return w;
  endfunction

  task automatic predict_subdivision(smd_pkg::in_word_t t);
    logic [19:0] v0, v1, v2, nxt, lim;
    smd_pkg::out_word_t w;
    bit done;
    v0 = first_new_index + 20'(3 * tri_counter);
    v1 = v0 + 20'd1;
    v2 = v0 + 20'd2;
    expect_word(sphere_vertex(half_sum(t.ax, t.bx), half_sum(t.ay, t.by),
                              half_sum(t.az, t.bz)));
    expect_word(sphere_vertex(half_sum(t.bx, t.cx), half_sum(t.by, t.cy),
                              half_sum(t.bz, t.cz)));
    expect_word(sphere_vertex(half_sum(t.cx, t.ax), half_sum(t.cy, t.ay),
                              half_sum(t.cz, t.az)));
    expect_word(tri_word(t.index_a, v0, v2));
    expect_word(tri_word(t.index_b, v1, v0));
    expect_word(tri_word(t.index_c, v2, v1));
    lim = tris_per_pass == 0 ? 20'd1 : tris_per_pass;
    nxt = tri_counter + 20'd1;
    done = nxt >= lim || nxt == 0;
    tri_counter = done ? 20'd0 : nxt;
    w = tri_word(v0, v1, v2);
    w.last = 1'b1;
    w.pass_done = done;
    expect_word(w);
  endtask

  // output side: stall pattern and checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", out_data);
      end else begin
        smd_pkg::out_word_t e;
        e = expected_words.pop_front();
        if (out_data !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [smd_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      smd_pkg::CFG_RADIUS: sph_radius = val[30:0];
      smd_pkg::CFG_VERTEX_BASE: first_new_index = val[19:0];
      smd_pkg::CFG_TRIANGLE_COUNT: tris_per_pass = val[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_triangle(smd_pkg::in_word_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_subdivision(t);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(signed'($urandom_range(8388608)) - 4194304);
    endcase
  endfunction

  function automatic smd_pkg::in_word_t rand_triangle();
    smd_pkg::in_word_t t;
    t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
    t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
    t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
    if ($urandom_range(9) == 0) begin
      t.bx = -t.ax; t.by = -t.ay; t.bz = -t.az;
    end
    t.index_a = 20'($urandom); t.index_b = 20'($urandom); t.index_c = 20'($urandom);
    return t;
  endfunction

  function automatic smd_pkg::in_word_t make_tri(int a, int b, int c, logic [19:0] ia);
    smd_pkg::in_word_t t;
    t = '0;
    t.ax = a; t.by = b; t.cz = c;
    t.index_a = ia; t.index_b = ia + 20'd1; t.index_c = ia + 20'd2;
    return t;
  endfunction

  task automatic add_row(smd_pkg::in_word_t t, bit typed, smd_pkg::out_word_t w);
    stim_row_t r;
    r.tri_in = t; r.typed = typed; r.first_word = w;
    stim_rows = {stim_rows, r};
  endtask

  initial begin
    smd_pkg::in_word_t t;
    smd_pkg::out_word_t w;
    sph_radius = 31'd65536;
    first_new_index = 20'd4;
    tris_per_pass = 20'd4;
    tri_counter = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: first word typed only where obvious
    w = '0;
    add_row('0, 1'b1, w);                              // zero midpoints
    t = make_tri(65536, 0, 0, 20'd0);
    t.bx = 32'sd65536;
    w = '0; w.pos_x = 32'sd65536; w.norm_x = 16'sd16384;
    add_row(t, 1'b1, w);                               // unit x on radius one
    t = make_tri(-65536, 0, 0, 20'hFFFFF);
    t.bx = -32'sd65536;
    w = '0; w.pos_x = -32'sd65536; w.norm_x = -16'sd16384;
    add_row(t, 1'b1, w);
    t = '1; add_row(t, 1'b0, w);
    t = '0; t.ax = 32'h7FFFFFFF; t.bx = 32'h7FFFFFFF; t.ay = 32'h80000000;
    t.by = 32'h80000000; t.cz = 32'h7FFFFFFF; add_row(t, 1'b0, w);
    t = '0; t.ax = 32'h80000000; t.bx = 32'h80000000; t.az = 32'h80000000;
    t.bz = 32'h80000000; t.index_a = 20'hFFFFF; add_row(t, 1'b0, w);
    t = make_tri(1, 1, 1, 20'd7); add_row(t, 1'b0, w);
    t = make_tri(-1, 3, -5, 20'd9); t.bx = 1; add_row(t, 1'b0, w);

    foreach (stim_rows[i]) begin
      send_triangle(stim_rows[i].tri_in);
      if (stim_rows[i].typed) begin
        int base;
        base = expected_words.size() - 7;
        if (expected_words[base] !== stim_rows[i].first_word) begin
          errors++;
          if (errors <= 10) $display("table row %0d: expected %p predicted %p",
                                     i, stim_rows[i].first_word, expected_words[base]);
        end
      end
    end
    wait_drained();

    // register extremes, including index wrap and a zero pass length
    write_reg(smd_pkg::CFG_RADIUS, 32'h7FFFFFFF);
    write_reg(smd_pkg::CFG_VERTEX_BASE, 32'hFFFFF);
    write_reg(smd_pkg::CFG_TRIANGLE_COUNT, 32'd0);
    write_reg(CFG_SPARE, $urandom);
    for (int i = 0; i < 4; i++) send_triangle(rand_triangle());
    wait_drained();
    write_reg(smd_pkg::CFG_RADIUS, 32'd0);
    write_reg(smd_pkg::CFG_TRIANGLE_COUNT, 32'hFFFFF);
    for (int i = 0; i < 3; i++) send_triangle(rand_triangle());
    wait_drained();
    write_reg(smd_pkg::CFG_TRIANGLE_COUNT, 32'd1);
    write_reg(smd_pkg::CFG_VERTEX_BASE, 32'd0);
    for (int i = 0; i < 3; i++) send_triangle(rand_triangle());
    wait_drained();

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(smd_pkg::CFG_RADIUS, $urandom_range(1 << 20));
      write_reg(smd_pkg::CFG_VERTEX_BASE, $urandom_range(20'hFFFFF));
      write_reg(smd_pkg::CFG_TRIANGLE_COUNT, $urandom_range(7, 1));
      if (ph == 4) hold_cycles = 2000;
      for (int i = 0; i < 48; i++) begin
        send_triangle(rand_triangle());
        if (i == 20) wait_drained();
      end
      wait_drained();
    end

    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
